@@ rtl/thick_line_rasterizer_core_assert.svh @@
// ----------------------------------------------------------------------------
// thick line rasterizer assertion macros
// concurrent checks clocked on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef THICK_LINE_RASTERIZER_CORE_ASSERT_SVH
`define THICK_LINE_RASTERIZER_CORE_ASSERT_SVH

// condition holds in the same cycle
`define TLR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("thick line rasterizer check failed");

// condition holds in the following cycle
`define TLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("thick line rasterizer check failed");

`endif

@@ rtl/tlr_pkg.sv @@
// ----------------------------------------------------------------------------
// tlr_pkg
// shared widths, defaults and codes of the thick line rasterizer
// ----------------------------------------------------------------------------
package tlr_pkg;

    localparam int DIM_BITS        = 12;
    localparam int ADDR_BITS       = 22;
    localparam int DEF_COORD_BITS  = 16;
    localparam int DEF_MAX_DIM     = 2048;

    localparam logic [DIM_BITS-1:0] RESET_WIDTH  = 12'd320;
    localparam logic [DIM_BITS-1:0] RESET_HEIGHT = 12'd240;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_STEP = 1'b1;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    typedef logic [2:0] status_t;

    localparam status_t STATUS_ACCEPTED    = 3'd0;
    localparam status_t STATUS_CULL_OFFSCR = 3'd1;
    localparam status_t STATUS_CULL_SHORT  = 3'd2;
    localparam status_t STATUS_PIXELS      = 3'd3;
    localparam status_t STATUS_IDLE        = 3'd4;

endpackage

@@ rtl/thick_line_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// thick line rasterizer core
// two pixel wide bresenham line engine producing framebuffer addresses
// ----------------------------------------------------------------------------
// Usage: a request on the s_ channel either loads a segment (s_action low)
// or advances the active segment by one step (s_action high). Every request
// gives exactly one result on the m_ channel: a load reports accepted or
// culled, a step on an active segment reports three row-major pixel
// addresses (center, right, below) with in-bounds flags and marks the step
// that reaches the far end; a step with no active segment reports idle.
// The pixel color is fixed and implied, so no color is carried. Screen
// width and height are set through the cfg_ write port; the user must write
// them only while idle, the block itself does not enforce this. A request
// passes the input register, then the step/load logic and a 13x13 multiply
// into the result register. Throughput is one request per cycle while
// m_ready is high, as the bresenham state registers update once per request.
// Reset clears the segment (steps report idle) and sets the screen to
// 320x240. When m_ready is low the result holds, an empty input register
// still takes one request, and then s_ready drops until the result leaves.
// ----------------------------------------------------------------------------
`include "thick_line_rasterizer_core_assert.svh"

module thick_line_rasterizer_core #(
    parameter int COORD_BITS = tlr_pkg::DEF_COORD_BITS,
    parameter int MAX_DIM    = tlr_pkg::DEF_MAX_DIM
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [tlr_pkg::DIM_BITS-1:0]      cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic signed [COORD_BITS-1:0]      s_x_start,
    input  logic signed [COORD_BITS-1:0]      s_y_start,
    input  logic signed [COORD_BITS-1:0]      s_x_end,
    input  logic signed [COORD_BITS-1:0]      s_y_end,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_status,
    output logic [tlr_pkg::ADDR_BITS-1:0]     m_addr_center,
    output logic                              m_valid_center,
    output logic [tlr_pkg::ADDR_BITS-1:0]     m_addr_right,
    output logic                              m_valid_right,
    output logic [tlr_pkg::ADDR_BITS-1:0]     m_addr_below,
    output logic                              m_valid_below,
    output logic                              m_last_step
);

    localparam int DB  = tlr_pkg::DIM_BITS;
    localparam int AB  = tlr_pkg::ADDR_BITS;
    localparam int VW  = ((COORD_BITS > DB) ? COORD_BITS : DB) + 2;
    localparam int SW  = COORD_BITS + 1;
    localparam int EW  = COORD_BITS + 2;
    localparam int E2W = COORD_BITS + 3;

    localparam logic signed [VW-1:0] ONE_V = VW'(1);
    localparam logic signed [VW-1:0] TWO_V = VW'(2);

    // configuration
    logic [DB-1:0] width_reg, height_reg;
    logic [DB-1:0] cfg_sat;

    assign cfg_sat = (cfg_wdata > MAX_DIM) ? DB'(MAX_DIM) : cfg_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= tlr_pkg::RESET_WIDTH;
            height_reg <= tlr_pkg::RESET_HEIGHT;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                tlr_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_sat;
                tlr_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_sat;
                default: ;
            endcase
        end
    end

    // input register
    logic                         in_valid_reg;
    logic                         in_action_reg;
    logic signed [COORD_BITS-1:0] in_x0_reg, in_y0_reg, in_x1_reg, in_y1_reg;
    logic                         out_valid_reg;
    logic                         advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_x0_reg     <= s_x_start;
            in_y0_reg     <= s_y_start;
            in_x1_reg     <= s_x_end;
            in_y1_reg     <= s_y_end;
        end
    end

    // bresenham state
    logic signed [COORD_BITS-1:0] cur_col_reg, cur_row_reg, goal_col_reg, goal_row_reg;
    logic signed [COORD_BITS-1:0] cur_col_next, cur_row_next, goal_col_next, goal_row_next;
    logic signed [SW-1:0]         span_col_reg, span_row_neg_reg;
    logic signed [SW-1:0]         span_col_next, span_row_neg_next;
    logic signed [EW-1:0]         error_term_reg, error_term_next;
    logic                         dir_col_neg_reg, dir_row_neg_reg, segment_active_reg;
    logic                         dir_col_neg_next, dir_row_neg_next, segment_active_next;

    // load path
    logic signed [VW-1:0] x0, y0, x1, y1, dx, dy, adx, ady, w_s, h_s;
    logic                 cull_off, cull_short;

    // step path
    logic signed [VW-1:0]        xc, yc, xr, yb;
    logic                        vis_c, vis_r, vis_b, at_goal;
    logic signed [DB:0]          y_m, w_m;
    logic signed [2*DB+1:0]      prod;
    logic [AB-1:0]               base;
    logic signed [E2W-1:0]       e2;
    logic                        step_col, step_row;
    logic signed [EW-1:0]        err_a;

    // result next values
    tlr_pkg::status_t status_next;
    logic [AB-1:0]    addr_c_next, addr_r_next, addr_b_next;
    logic             vc_next, vr_next, vb_next, last_next;

    assign w_s = signed'(VW'(width_reg));
    assign h_s = signed'(VW'(height_reg));

    assign x0  = VW'(in_x0_reg);
    assign y0  = VW'(in_y0_reg);
    assign x1  = VW'(in_x1_reg);
    assign y1  = VW'(in_y1_reg);
    assign dx  = x1 - x0;
    assign dy  = y1 - y0;
    assign adx = dx[VW-1] ? -dx : dx;
    assign ady = dy[VW-1] ? -dy : dy;

    assign cull_off = (x0[VW-1] && x1[VW-1]) || (x0 >= w_s && x1 >= w_s) ||
                      (y0[VW-1] && y1[VW-1]) || (y0 >= h_s && y1 >= h_s);
    assign cull_short = (adx < TWO_V) && (ady < TWO_V);

    assign xc = VW'(cur_col_reg);
    assign yc = VW'(cur_row_reg);
    assign xr = xc + ONE_V;
    assign yb = yc + ONE_V;

    assign vis_c = !xc[VW-1] && (xc < w_s) && !yc[VW-1] && (yc < h_s);
    assign vis_r = !xr[VW-1] && (xr < w_s) && !yc[VW-1] && (yc < h_s);
    assign vis_b = !xc[VW-1] && (xc < w_s) && !yb[VW-1] && (yb < h_s);

    assign y_m  = yc[DB:0];
    assign w_m  = signed'({1'b0, width_reg});
    assign prod = y_m * w_m;
    assign base = AB'(prod) + AB'(xc);

    assign at_goal = (cur_col_reg == goal_col_reg) && (cur_row_reg == goal_row_reg);

    assign e2       = E2W'(error_term_reg) <<< 1;
    assign step_col = e2 >= E2W'(span_row_neg_reg);
    assign step_row = e2 <= E2W'(span_col_reg);
    assign err_a    = step_col ? error_term_reg + EW'(span_row_neg_reg) : error_term_reg;

    always_comb begin
        cur_col_next        = cur_col_reg;
        cur_row_next        = cur_row_reg;
        goal_col_next       = goal_col_reg;
        goal_row_next       = goal_row_reg;
        span_col_next       = span_col_reg;
        span_row_neg_next   = span_row_neg_reg;
        error_term_next     = error_term_reg;
        dir_col_neg_next    = dir_col_neg_reg;
        dir_row_neg_next    = dir_row_neg_reg;
        segment_active_next = segment_active_reg;

        status_next = tlr_pkg::STATUS_IDLE;
        addr_c_next = '0;
        addr_r_next = '0;
        addr_b_next = '0;
        vc_next     = 1'b0;
        vr_next     = 1'b0;
        vb_next     = 1'b0;
        last_next   = 1'b0;

        if (in_action_reg == tlr_pkg::ACTION_LOAD) begin
            segment_active_next = 1'b0;
            if (cull_off) begin
                status_next = tlr_pkg::STATUS_CULL_OFFSCR;
            end else if (cull_short) begin
                status_next = tlr_pkg::STATUS_CULL_SHORT;
            end else begin
                status_next         = tlr_pkg::STATUS_ACCEPTED;
                cur_col_next        = in_x0_reg;
                cur_row_next        = in_y0_reg;
                goal_col_next       = in_x1_reg;
                goal_row_next       = in_y1_reg;
                span_col_next       = SW'(adx);
                span_row_neg_next   = SW'(-ady);
                error_term_next     = EW'(adx - ady);
                dir_col_neg_next    = !(x0 < x1);
                dir_row_neg_next    = !(y0 < y1);
                segment_active_next = 1'b1;
            end
        end else if (segment_active_reg) begin
            status_next = tlr_pkg::STATUS_PIXELS;
            vc_next     = vis_c;
            vr_next     = vis_r;
            vb_next     = vis_b;
            addr_c_next = vis_c ? base : '0;
            addr_r_next = vis_r ? base + AB'(1) : '0;
            addr_b_next = vis_b ? base + AB'(width_reg) : '0;
            if (at_goal) begin
                last_next           = 1'b1;
                segment_active_next = 1'b0;
            end else begin
                error_term_next = step_row ? err_a + EW'(span_col_reg) : err_a;
                if (step_col) begin
                    cur_col_next = dir_col_neg_reg ? cur_col_reg - COORD_BITS'(1)
                                                   : cur_col_reg + COORD_BITS'(1);
                end
                if (step_row) begin
                    cur_row_next = dir_row_neg_reg ? cur_row_reg - COORD_BITS'(1)
                                                   : cur_row_reg + COORD_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg        <= '0;
            cur_row_reg        <= '0;
            goal_col_reg       <= '0;
            goal_row_reg       <= '0;
            span_col_reg       <= '0;
            span_row_neg_reg   <= '0;
            error_term_reg     <= '0;
            dir_col_neg_reg    <= 1'b0;
            dir_row_neg_reg    <= 1'b0;
            segment_active_reg <= 1'b0;
        end else if (advance) begin
            cur_col_reg        <= cur_col_next;
            cur_row_reg        <= cur_row_next;
            goal_col_reg       <= goal_col_next;
            goal_row_reg       <= goal_row_next;
            span_col_reg       <= span_col_next;
            span_row_neg_reg   <= span_row_neg_next;
            error_term_reg     <= error_term_next;
            dir_col_neg_reg    <= dir_col_neg_next;
            dir_row_neg_reg    <= dir_row_neg_next;
            segment_active_reg <= segment_active_next;
        end
    end

    // result register
    tlr_pkg::status_t status_reg;
    logic [AB-1:0]    addr_c_reg, addr_r_reg, addr_b_reg;
    logic             vc_reg, vr_reg, vb_reg, last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg <= status_next;
            addr_c_reg <= addr_c_next;
            addr_r_reg <= addr_r_next;
            addr_b_reg <= addr_b_next;
            vc_reg     <= vc_next;
            vr_reg     <= vr_next;
            vb_reg     <= vb_next;
            last_reg   <= last_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = status_reg;
    assign m_addr_center  = addr_c_reg;
    assign m_valid_center = vc_reg;
    assign m_addr_right   = addr_r_reg;
    assign m_valid_right  = vr_reg;
    assign m_addr_below   = addr_b_reg;
    assign m_valid_below  = vb_reg;
    assign m_last_step    = last_reg;

    // checks
    `TLR_ASSERT_SAME(a_non_pixel_zero, m_valid && (m_status != tlr_pkg::STATUS_PIXELS), !(m_valid_center || m_valid_right || m_valid_below || m_last_step) && ((m_addr_center | m_addr_right | m_addr_below) == '0))
    `TLR_ASSERT_SAME(a_offscreen_addr_zero, m_valid, (m_valid_center || m_addr_center == '0) && (m_valid_right || m_addr_right == '0) && (m_valid_below || m_addr_below == '0))
    `TLR_ASSERT_SAME(a_empty_out_ready, !out_valid_reg, s_ready)
    `TLR_ASSERT_NEXT(a_advance_gives_result, advance, m_valid)
    `TLR_ASSERT_NEXT(a_last_ends_segment, advance && (in_action_reg == tlr_pkg::ACTION_STEP) && segment_active_reg && at_goal, !segment_active_reg && m_last_step)

endmodule
